### hw/rtl/lwsc_pkg.sv
// ----------------------------------------------------------------------------
// lwsc_pkg
// Shared types, register indexes, fixed-point constants and the arctangent
// table of the line-of-sight waypoint steering controller.
// ----------------------------------------------------------------------------
package lwsc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_THRUST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_SLEW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRUST_SLEW   = 3'd6;

    // fixed-point constants
    localparam logic [17:0] PI_Q16       = 18'd205887;
    localparam logic [17:0] PWM_GAIN_Q16 = 18'd109229;
    localparam logic signed [17:0] STEER_SAT_Q8 = 18'sd76800;
    localparam logic [15:0] ANGLE_PI     = 16'd32768;
    localparam logic [10:0] PWM_MIN      = 11'd1000;
    localparam logic [10:0] PWM_MID      = 11'd1500;
    localparam logic [10:0] PWM_MAX      = 11'd2000;
    localparam logic [11:0] PWM_SPAN     = 12'd500;

    // datapath operations, one per controller step
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_ACCEPT,
        OP_READ,
        OP_DIFF,
        OP_PRE,
        OP_ROT,
        OP_ERR,
        OP_MUL_P,
        OP_MUL_D,
        OP_SUM,
        OP_MUL_HI,
        OP_MUL_LO,
        OP_DEMAND,
        OP_SLEW,
        OP_MUL_PWM,
        OP_MUL_DX,
        OP_MUL_DY,
        OP_MUL_R,
        OP_FINISH
    } dp_op_t;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_PRE,
        S_ROT,
        S_ERR,
        S_MUL_P,
        S_MUL_D,
        S_SUM,
        S_MUL_HI,
        S_MUL_LO,
        S_DEMAND,
        S_SLEW,
        S_MUL_PWM,
        S_MUL_DX,
        S_MUL_DY,
        S_MUL_R,
        S_FINISH
    } state_t;

    // datapath status back to the controller
    typedef struct packed {
        logic list_empty;
        logic rot_last;
    } dp_status_t;

    // arctangent table, binary angle, zero past the end
    function automatic logic [15:0] atan_entry(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd8192;
            5'd1:    v = 16'd4836;
            5'd2:    v = 16'd2555;
            5'd3:    v = 16'd1297;
            5'd4:    v = 16'd651;
            5'd5:    v = 16'd326;
            5'd6:    v = 16'd163;
            5'd7:    v = 16'd81;
            5'd8:    v = 16'd41;
            5'd9:    v = 16'd20;
            5'd10:   v = 16'd10;
            5'd11:   v = 16'd5;
            5'd12:   v = 16'd3;
            5'd13:   v = 16'd1;
            5'd14:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/los_waypoint_steering_controller_core.sv
// ----------------------------------------------------------------------------
// los_waypoint_steering_controller_core
// Line-of-sight waypoint steering: CORDIC bearing, PD steer, slew limits,
// PWM outputs and waypoint advance on arrival.
// ----------------------------------------------------------------------------
// A store beat is taken in idle. A control beat on an empty list gives no
// result; otherwise it runs through fixed steps around the shared multiplier
// and one CORDIC rotation per cycle. New beats are taken only in idle.
// Reset clears the list, the waypoint index, the steer/thrust history and
// loads the register defaults; waypoint memory contents are not cleared.
// ----------------------------------------------------------------------------
module los_waypoint_steering_controller_core
    import lwsc_pkg::*;
#(
    parameter int MAX_WAYPOINTS = 64,
    parameter int CORDIC_STEPS  = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [CFG_IDX_W-1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]              cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               command,
    input  logic                               list_start,
    input  logic signed [31:0]                 east_pos,
    input  logic signed [31:0]                 north_pos,
    input  logic signed [15:0]                 heading,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [10:0]                        steer_pwm,
    output logic [10:0]                        thrust_pwm,
    output logic [$clog2(MAX_WAYPOINTS)-1:0]   target_slot,
    output logic                               arrived
);

    dp_op_t     op;
    dp_status_t status;

    // sequencer
    lwsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .op        (op)
    );

    // datapath
    lwsc_datapath #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .command     (command),
        .list_start  (list_start),
        .east_pos    (east_pos),
        .north_pos   (north_pos),
        .heading     (heading),
        .steer_pwm   (steer_pwm),
        .thrust_pwm  (thrust_pwm),
        .target_slot (target_slot),
        .arrived     (arrived)
    );

endmodule

### hw/rtl/lwsc_datapath.sv
// ----------------------------------------------------------------------------
// lwsc_datapath
// Waypoint memory, CORDIC bearing, shared 18x18 multiplier, PD steer with
// clamp and slew limits, PWM mapping and waypoint arrival logic.
// ----------------------------------------------------------------------------
module lwsc_datapath
    import lwsc_pkg::*;
#(
    parameter int MAX_WAYPOINTS = 64,
    parameter int CORDIC_STEPS  = 16,
    localparam int AW = $clog2(MAX_WAYPOINTS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_op_t                op,
    output dp_status_t            status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  command,
    input  logic                  list_start,
    input  logic signed [31:0]    east_pos,
    input  logic signed [31:0]    north_pos,
    input  logic signed [15:0]    heading,
    output logic [10:0]           steer_pwm,
    output logic [10:0]           thrust_pwm,
    output logic [AW-1:0]         target_slot,
    output logic                  arrived
);

    // waypoint store
    logic signed [31:0] east_mem [MAX_WAYPOINTS];
    logic signed [31:0] north_mem [MAX_WAYPOINTS];

    // configuration
    logic [15:0]        accept_radius_reg;
    logic [15:0]        prop_gain_reg;
    logic [15:0]        deriv_gain_reg;
    logic signed [15:0] cruise_thrust_reg;
    logic [16:0]        steer_limit_reg;
    logic [16:0]        steer_slew_reg;
    logic [15:0]        thrust_slew_reg;

    // control state
    logic [AW:0]        total_reg;
    logic [AW-1:0]      idx_reg;
    logic signed [15:0] prev_err_reg;
    logic signed [17:0] steer_reg;
    logic signed [15:0] thrust_reg;

    // working registers
    logic signed [31:0] pos_e_reg, pos_n_reg, wpt_e_reg, wpt_n_reg;
    logic [15:0]        hdg_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [35:0] x_reg, y_reg;
    logic [15:0]        z_reg;
    logic [4:0]         iter_reg;
    logic               zero_reg;
    logic signed [15:0] err_reg;
    logic signed [16:0] diff_reg;
    logic [35:0]        prod_reg;
    logic [35:0]        hi_reg;
    logic signed [34:0] acc_reg;
    logic [33:0]        smag_reg;
    logic               sneg_reg;
    logic signed [17:0] dem_reg;
    logic [10:0]        spwm_reg, tpwm_reg;
    logic [32:0]        d2_reg;
    logic [10:0]        steer_pwm_reg, thrust_pwm_reg;
    logic [AW-1:0]      slot_reg;
    logic               arrived_reg;

    // store addressing and index wrap
    logic [AW:0]   tot_store;
    logic          store_ok;
    logic [AW-1:0] idx_wrap;
    logic [AW:0]   idx_inc;

    assign tot_store = list_start ? '0 : total_reg;
    assign store_ok  = tot_store < (AW+1)'(MAX_WAYPOINTS);
    assign idx_wrap  = ({1'b0, idx_reg} >= total_reg) ? '0 : idx_reg;
    assign idx_inc   = {1'b0, idx_reg} + (AW+1)'(1);

    assign status.list_empty = (total_reg == '0);
    assign status.rot_last   = (iter_reg == 5'(CORDIC_STEPS - 1));

    // offset magnitudes
    logic [32:0] adx, ady;
    logic        in_range;

    assign adx      = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign ady      = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign in_range = (adx < 33'd65536) && (ady < 33'd65536);

    // cordic pre-rotation and micro-rotation
    logic signed [35:0] dx_ext, dy_ext, xs, ys;
    logic signed [35:0] x_rot, y_rot;
    logic [15:0]        z_rot, tab;

    assign dx_ext = 36'(dx_reg);
    assign dy_ext = 36'(dy_reg);
    assign xs     = x_reg >>> iter_reg;
    assign ys     = y_reg >>> iter_reg;
    assign tab    = atan_entry(iter_reg);

    always_comb
    begin
        if (!y_reg[35])
        begin
            x_rot = x_reg + ys;
            y_rot = y_reg - xs;
            z_rot = z_reg + tab;
        end
        else
        begin
            x_rot = x_reg - ys;
            y_rot = y_reg + xs;
            z_rot = z_reg - tab;
        end
    end

    // heading error and its change
    logic [15:0]        eraw;
    logic signed [15:0] err_next;
    logic signed [16:0] diff_next, err_ext;
    logic [16:0]        aerr, adiff;

    assign eraw      = (zero_reg ? 16'd0 : z_reg) - hdg_reg;
    assign err_next  = signed'(eraw);
    assign diff_next = {err_next[15], err_next} - {prev_err_reg[15], prev_err_reg};
    assign err_ext   = {err_reg[15], err_reg};
    assign aerr      = err_ext[16] ? 17'(-err_ext) : 17'(err_ext);
    assign adiff     = diff_reg[16] ? 17'(-diff_reg) : 17'(diff_reg);

    // steer magnitude
    logic [17:0] asteer;

    assign asteer = steer_reg[17] ? 18'(-steer_reg) : 18'(steer_reg);

    // shared multiplier operand select
    logic [17:0] mul_a, mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_MUL_P:
            begin
                mul_a = 18'(prop_gain_reg);
                mul_b = 18'(aerr);
            end
            OP_MUL_D:
            begin
                mul_a = 18'(deriv_gain_reg);
                mul_b = 18'(adiff);
            end
            OP_MUL_HI:
            begin
                mul_a = 18'(smag_reg[33:18]);
                mul_b = PI_Q16;
            end
            OP_MUL_LO:
            begin
                mul_a = smag_reg[17:0];
                mul_b = PI_Q16;
            end
            OP_MUL_PWM:
            begin
                mul_a = asteer;
                mul_b = PWM_GAIN_Q16;
            end
            OP_MUL_DX:
            begin
                mul_a = 18'(adx[16:0]);
                mul_b = 18'(adx[16:0]);
            end
            OP_MUL_DY:
            begin
                mul_a = 18'(ady[16:0]);
                mul_b = 18'(ady[16:0]);
            end
            OP_MUL_R:
            begin
                mul_a = 18'(accept_radius_reg);
                mul_b = 18'(accept_radius_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // pd sum
    logic signed [34:0] pterm, sum_next;

    assign pterm    = signed'(35'(prod_reg));
    assign sum_next = acc_reg + (diff_reg[16] ? -pterm : pterm);

    // rounding and clamp of the steer demand
    logic [52:0] dmag53;
    logic [23:0] drnd;
    logic [16:0] dclip;

    assign dmag53 = {hi_reg[34:0], 18'd0} + 53'(prod_reg) + 53'd268435456;
    assign drnd   = dmag53[52:29];
    assign dclip  = (drnd > 24'(steer_limit_reg)) ? steer_limit_reg : drnd[16:0];

    // slew limits
    logic signed [18:0] sdelta, slim, ssum;
    logic signed [16:0] tdelta, tlim, tsum;
    logic signed [18:0] sdelta_c;
    logic signed [16:0] tdelta_c;

    assign sdelta = 19'(dem_reg) - 19'(steer_reg);
    assign slim   = signed'({2'b00, steer_slew_reg});
    assign tdelta = 17'(cruise_thrust_reg) - 17'(thrust_reg);
    assign tlim   = signed'({1'b0, thrust_slew_reg});

    always_comb
    begin
        if (sdelta > slim)
            sdelta_c = slim;
        else if (sdelta < -slim)
            sdelta_c = -slim;
        else
            sdelta_c = sdelta;
        if (tdelta > tlim)
            tdelta_c = tlim;
        else if (tdelta < -tlim)
            tdelta_c = -tlim;
        else
            tdelta_c = tdelta;
    end

    assign ssum = 19'(steer_reg) + sdelta_c;
    assign tsum = 17'(thrust_reg) + tdelta_c;

    // pwm mapping
    logic [19:0] t5;
    logic [11:0] tadd;
    logic [10:0] tpwm_next;
    logic [35:0] prnd;
    logic [11:0] srnd, sclip;
    logic [10:0] spwm_next;

    assign t5   = 20'({4'd0, thrust_reg[15:0]}) * 20'd5 + 20'd128;
    assign tadd = t5[19:8];
    assign prnd = prod_reg + 36'd8388608;
    assign srnd = prnd[35:24];
    assign sclip = (srnd > PWM_SPAN) ? PWM_SPAN : srnd;

    always_comb
    begin
        if (thrust_reg <= 16'sd0)
            tpwm_next = PWM_MID;
        else if (tadd > PWM_SPAN)
            tpwm_next = PWM_MAX;
        else
            tpwm_next = PWM_MID + 11'(tadd);
        if (steer_reg >= STEER_SAT_Q8)
            spwm_next = PWM_MAX;
        else if (steer_reg <= -STEER_SAT_Q8)
            spwm_next = PWM_MIN;
        else if (steer_reg[17])
            spwm_next = PWM_MID - 11'(sclip);
        else
            spwm_next = PWM_MID + 11'(sclip);
    end

    // arrival
    logic arrive;

    assign arrive = in_range && (d2_reg < 33'(prod_reg));

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_radius_reg <= 16'd48;
            prop_gain_reg     <= 16'd19200;
            deriv_gain_reg    <= 16'd0;
            cruise_thrust_reg <= 16'sd12800;
            steer_limit_reg   <= 17'd25600;
            steer_slew_reg    <= 17'd26;
            thrust_slew_reg   <= 16'd26;
            total_reg         <= '0;
            idx_reg           <= '0;
            prev_err_reg      <= '0;
            steer_reg         <= '0;
            thrust_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ACCEPT_RADIUS: accept_radius_reg <= cfg_data[15:0];
                    CFG_PROP_GAIN:     prop_gain_reg     <= cfg_data[15:0];
                    CFG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data[15:0];
                    CFG_CRUISE_THRUST: cruise_thrust_reg <= signed'(cfg_data[15:0]);
                    CFG_STEER_LIMIT:   steer_limit_reg   <= cfg_data;
                    CFG_STEER_SLEW:    steer_slew_reg    <= cfg_data;
                    CFG_THRUST_SLEW:   thrust_slew_reg   <= cfg_data[15:0];
                    default:           ;
                endcase
            end
            case (op)
                OP_ACCEPT:
                begin
                    if (command)
                        idx_reg <= idx_wrap;
                    else if (store_ok)
                        total_reg <= tot_store + (AW+1)'(1);
                    else
                        total_reg <= tot_store;
                end
                OP_ERR:
                    prev_err_reg <= err_next;
                OP_SLEW:
                begin
                    steer_reg  <= ssum[17:0];
                    thrust_reg <= tsum[15:0];
                end
                OP_FINISH:
                begin
                    if (arrive)
                        idx_reg <= (idx_inc >= total_reg) ? '0 : idx_inc[AW-1:0];
                end
                default:
                    ;
            endcase
        end
    end

    // waypoint memory write and registered read
    always_ff @(posedge clk)
    begin
        if (op == OP_ACCEPT && !command && store_ok)
        begin
            east_mem[tot_store[AW-1:0]]  <= east_pos;
            north_mem[tot_store[AW-1:0]] <= north_pos;
        end
        if (op == OP_READ)
        begin
            wpt_e_reg <= east_mem[idx_reg];
            wpt_n_reg <= north_mem[idx_reg];
        end
    end

    // working datapath registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_ACCEPT:
            begin
                pos_e_reg <= east_pos;
                pos_n_reg <= north_pos;
                hdg_reg   <= heading;
            end
            OP_DIFF:
            begin
                dx_reg <= 33'(wpt_e_reg) - 33'(pos_e_reg);
                dy_reg <= 33'(wpt_n_reg) - 33'(pos_n_reg);
            end
            OP_PRE:
            begin
                zero_reg <= (dx_reg == '0) && (dy_reg == '0);
                iter_reg <= '0;
                if (dx_reg[32])
                begin
                    x_reg <= -dx_ext;
                    y_reg <= -dy_ext;
                    z_reg <= ANGLE_PI;
                end
                else
                begin
                    x_reg <= dx_ext;
                    y_reg <= dy_ext;
                    z_reg <= '0;
                end
            end
            OP_ROT:
            begin
                x_reg    <= x_rot;
                y_reg    <= y_rot;
                z_reg    <= z_rot;
                iter_reg <= iter_reg + 5'd1;
            end
            OP_ERR:
            begin
                err_reg  <= err_next;
                diff_reg <= diff_next;
            end
            OP_MUL_D:
                acc_reg <= err_reg[15] ? -pterm : pterm;
            OP_SUM:
            begin
                sneg_reg <= sum_next[34];
                smag_reg <= sum_next[34] ? 34'(-sum_next) : 34'(sum_next);
            end
            OP_MUL_LO:
                hi_reg <= prod_reg;
            OP_DEMAND:
                dem_reg <= sneg_reg ? -18'(dclip) : 18'(dclip);
            OP_MUL_PWM:
                tpwm_reg <= tpwm_next;
            OP_MUL_DX:
                spwm_reg <= spwm_next;
            OP_MUL_DY:
                d2_reg <= 33'(prod_reg);
            OP_MUL_R:
                d2_reg <= d2_reg + 33'(prod_reg);
            OP_FINISH:
            begin
                steer_pwm_reg  <= spwm_reg;
                thrust_pwm_reg <= tpwm_reg;
                slot_reg       <= idx_reg;
                arrived_reg    <= arrive;
            end
            default:
                ;
        endcase
        // product register of the shared multiplier
        if (op == OP_MUL_P || op == OP_MUL_D || op == OP_MUL_HI || op == OP_MUL_LO ||
            op == OP_MUL_PWM || op == OP_MUL_DX || op == OP_MUL_DY || op == OP_MUL_R)
            prod_reg <= mul_a * mul_b;
    end

    assign steer_pwm   = steer_pwm_reg;
    assign thrust_pwm  = thrust_pwm_reg;
    assign target_slot = slot_reg;
    assign arrived     = arrived_reg;

    // list never grows past capacity
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= (AW+1)'(MAX_WAYPOINTS))
        else $error("waypoint count past capacity");

    // after a finished step the index points inside the list
    a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_FINISH |=> {1'b0, idx_reg} < total_reg)
        else $error("waypoint index outside list after step");

    // steer pwm stays within its range
    a_spwm_range: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_FINISH |=> (steer_pwm >= PWM_MIN) && (steer_pwm <= PWM_MAX))
        else $error("steer pwm out of range");

    // thrust pwm stays within its range
    a_tpwm_range: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_FINISH |=> (thrust_pwm >= PWM_MID) && (thrust_pwm <= PWM_MAX))
        else $error("thrust pwm out of range");

endmodule

### hw/rtl/lwsc_ctrl.sv
// ----------------------------------------------------------------------------
// lwsc_ctrl
// Sequencer of one control step: waypoint read, CORDIC iterations, multiply
// steps and result hand-off to the output register.
// ----------------------------------------------------------------------------
module lwsc_ctrl
    import lwsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_op_t     op
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   fire;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign fire      = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (fire && command && !status.list_empty)
                    state_next = S_READ;
            S_READ:    state_next = S_DIFF;
            S_DIFF:    state_next = S_PRE;
            S_PRE:     state_next = S_ROT;
            S_ROT:
                if (status.rot_last)
                    state_next = S_ERR;
            S_ERR:     state_next = S_MUL_P;
            S_MUL_P:   state_next = S_MUL_D;
            S_MUL_D:   state_next = S_SUM;
            S_SUM:     state_next = S_MUL_HI;
            S_MUL_HI:  state_next = S_MUL_LO;
            S_MUL_LO:  state_next = S_DEMAND;
            S_DEMAND:  state_next = S_SLEW;
            S_SLEW:    state_next = S_MUL_PWM;
            S_MUL_PWM: state_next = S_MUL_DX;
            S_MUL_DX:  state_next = S_MUL_DY;
            S_MUL_DY:  state_next = S_MUL_R;
            S_MUL_R:   state_next = S_FINISH;
            S_FINISH:
                if (slot_free)
                    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath command
    always_comb
    begin
        op = OP_IDLE;
        unique case (state_reg)
            S_IDLE:    op = fire ? OP_ACCEPT : OP_IDLE;
            S_READ:    op = OP_READ;
            S_DIFF:    op = OP_DIFF;
            S_PRE:     op = OP_PRE;
            S_ROT:     op = OP_ROT;
            S_ERR:     op = OP_ERR;
            S_MUL_P:   op = OP_MUL_P;
            S_MUL_D:   op = OP_MUL_D;
            S_SUM:     op = OP_SUM;
            S_MUL_HI:  op = OP_MUL_HI;
            S_MUL_LO:  op = OP_MUL_LO;
            S_DEMAND:  op = OP_DEMAND;
            S_SLEW:    op = OP_SLEW;
            S_MUL_PWM: op = OP_MUL_PWM;
            S_MUL_DX:  op = OP_MUL_DX;
            S_MUL_DY:  op = OP_MUL_DY;
            S_MUL_R:   op = OP_MUL_R;
            S_FINISH:  op = slot_free ? OP_FINISH : OP_IDLE;
            default:   op = OP_IDLE;
        endcase
    end

    // output beat valid
    always_comb
    begin
        if (op == OP_FINISH)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a result is only loaded into a free output slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_FINISH |-> !out_valid_reg || out_ready)
        else $error("result beat overwritten");

    // rotation steps are only left on the last step
    a_rot_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROT && !status.rot_last |=> state_reg == S_ROT)
        else $error("cordic left early");

    // a waiting result holds the sequencer in finish
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && !slot_free |=> state_reg == S_FINISH)
        else $error("finish left while output busy");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line-of-sight waypoint steering controller.
// Waypoint loads and control beats are fed from a queue with random gaps.
// Each accepted beat runs through a local steering-law predictor. Results are
// taken under random back-pressure and checked field by field. The run goes
// through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
    import lwsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WPT_CAP   = 64;
    localparam int ROT_STEPS = 16;
    localparam int SETTLE    = 80;

    localparam logic CMD_STORE   = 1'b0;
    localparam logic CMD_CONTROL = 1'b1;

    localparam int ATAN_BAM [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                     41, 20, 10, 5, 3, 1, 1, 0};

    typedef struct {
        logic              cmd;
        logic              clr;
        logic signed [31:0] e;
        logic signed [31:0] n;
        logic signed [15:0] hdg;
    } nav_beat_t;

    typedef struct {
        logic [10:0] steer;
        logic [10:0] thrust;
        logic [5:0]  slot;
        logic        hit;
    } actuator_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic command = 1'b0;
    logic list_start = 1'b0;
    logic signed [31:0] east_pos = '0;
    logic signed [31:0] north_pos = '0;
    logic signed [15:0] heading = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [10:0] steer_pwm;
    logic [10:0] thrust_pwm;
    logic [5:0] target_slot;
    logic arrived;

    los_waypoint_steering_controller_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .list_start(list_start),
        .east_pos(east_pos), .north_pos(north_pos), .heading(heading),
        .out_valid(out_valid), .out_ready(out_ready),
        .steer_pwm(steer_pwm), .thrust_pwm(thrust_pwm),
        .target_slot(target_slot), .arrived(arrived)
    );

    always #5 clk = ~clk;

    // predictor state
    int          route_e [WPT_CAP];
    int          route_n [WPT_CAP];
    int          route_len = 0;
    int          route_idx = 0;
    int          last_err = 0;
    longint      last_steer = 0;
    longint      thrust_hist = 0;
    longint      r_accept = 48, r_kp = 19200, r_kd = 0, r_cruise = 12800;
    longint      r_slim = 25600, r_sslew = 26, r_tslew = 26;

    nav_beat_t     nav_queue [$];
    actuator_cmd_t cmd_due [$];
    int            mismatches = 0;
    int            gap_cap = 11;
    int            stall_cap = 11;
    int            gap_left = 0;
    int            stall_left = 0;

    // stimulus-side shadow of the loaded route, used to aim near waypoints
    int          plan_e [$];
    int          plan_n [$];

    function automatic longint half_away_shift(longint v, int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // cordic atan2 in binary angle, pre-rotated by pi for negative x
    function automatic logic [15:0] los_bearing(longint x, longint y);
        logic [15:0] z;
        longint xs;
        longint ys;
        z = '0;
        if (x == 0 && y == 0)
            return '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = ANGLE_PI;
        end
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += 16'(ATAN_BAM[i]);
            end
            else
            begin
                x -= ys; y += xs; z -= 16'(ATAN_BAM[i]);
            end
        end
        return z;
    endfunction

    // one steering-law step; queues the actuator command it produces
    function automatic void steering_law_step(nav_beat_t b);
        longint dx, dy, demand, steer, thrust, spwm, tpwm, d2;
        logic [15:0] eraw;
        int err;
        int tgt;
        logic hit;
        actuator_cmd_t r;
        if (b.cmd == CMD_STORE)
        begin
            if (b.clr)
                route_len = 0;
            if (route_len < WPT_CAP)
            begin
                route_e[route_len] = b.e;
                route_n[route_len] = b.n;
                route_len++;
            end
            return;
        end
        if (route_idx >= route_len)
            route_idx = 0;
        if (route_len == 0)
            return;
        tgt = route_idx;
        dx = longint'(route_e[tgt]) - longint'(b.e);
        dy = longint'(route_n[tgt]) - longint'(b.n);
        eraw = los_bearing(dx, dy) - b.hdg;
        err = int'($signed(eraw));

        // pd demand, clamp, then slew limits
        demand = (r_kp * err + r_kd * (longint'(err) - last_err)) * 205887;
        demand = clip(half_away_shift(demand, 29), -r_slim, r_slim);
        last_err = err;
        steer = last_steer + clip(demand - last_steer, -r_sslew, r_sslew);
        last_steer = steer;
        thrust = thrust_hist + clip(r_cruise - thrust_hist, -r_tslew, r_tslew);
        thrust_hist = thrust;

        // pwm mapping
        if (steer >= 76800)
            spwm = 2000;
        else if (steer <= -76800)
            spwm = 1000;
        else
            spwm = 1500 + clip(half_away_shift(steer * 109229, 24), -500, 500);
        if (thrust <= 0)
            tpwm = 1500;
        else
            tpwm = clip(1500 + ((thrust * 5 + 128) >>> 8), 1500, 2000);

        // arrival check and waypoint advance
        hit = 1'b0;
        if (dx > -65536 && dx < 65536 && dy > -65536 && dy < 65536)
        begin
            d2 = dx * dx + dy * dy;
            if (d2 < r_accept * r_accept)
                hit = 1'b1;
        end
        if (hit)
        begin
            route_idx = tgt + 1;
            if (route_idx >= route_len)
                route_idx = 0;
        end
        r.steer = 11'(spwm);
        r.thrust = 11'(tpwm);
        r.slot = 6'(tgt);
        r.hit = hit;
        cmd_due.push_back(r);
    endfunction

    // input driver
    always @(posedge clk)
    begin
        nav_beat_t b;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                b.cmd = command; b.clr = list_start; b.e = east_pos;
                b.n = north_pos; b.hdg = heading;
                steering_law_step(b);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (nav_queue.size() > 0)
                begin
                    b = nav_queue.pop_front();
                    command <= b.cmd; list_start <= b.clr;
                    east_pos <= b.e; north_pos <= b.n; heading <= b.hdg;
                    in_valid <= 1'b1;
                    gap_left <= $urandom_range(0, gap_cap);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk)
    begin
        actuator_cmd_t x;
        int s;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (cmd_due.size() == 0)
                begin
                    $error("unexpected result beat, slot %0d", target_slot);
                    mismatches++;
                end
                else
                begin
                    x = cmd_due.pop_front();
                    if (steer_pwm !== x.steer)
                    begin
                        $error("steer_pwm expected %0d got %0d", x.steer, steer_pwm);
                        mismatches++;
                    end
                    if (thrust_pwm !== x.thrust)
                    begin
                        $error("thrust_pwm expected %0d got %0d", x.thrust, thrust_pwm);
                        mismatches++;
                    end
                    if (target_slot !== x.slot)
                    begin
                        $error("target_slot expected %0d got %0d", x.slot, target_slot);
                        mismatches++;
                    end
                    if (arrived !== x.hit)
                    begin
                        $error("arrived expected %0d got %0d", x.hit, arrived);
                        mismatches++;
                    end
                end
                s = $urandom_range(0, stall_cap);
                stall_left <= s;
                out_ready <= (s == 0);
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= (stall_left == 1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic push_beat(logic cmd, logic clr, int e, int n, int hdg);
        nav_beat_t b;
        b.cmd = cmd; b.clr = clr; b.e = e; b.n = n; b.hdg = 16'(hdg);
        nav_queue.push_back(b);
        if (cmd == CMD_STORE)
        begin
            if (clr)
            begin
                plan_e.delete();
                plan_n.delete();
            end
            if (plan_e.size() < WPT_CAP)
            begin
                plan_e.push_back(e);
                plan_n.push_back(n);
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        case (idx)
            CFG_ACCEPT_RADIUS: r_accept = val & 16'hFFFF;
            CFG_PROP_GAIN:     r_kp = val & 16'hFFFF;
            CFG_DERIV_GAIN:    r_kd = val & 16'hFFFF;
            CFG_CRUISE_THRUST: r_cruise = longint'($signed(16'(val)));
            CFG_STEER_LIMIT:   r_slim = val & 17'h1FFFF;
            CFG_STEER_SLEW:    r_sslew = val & 17'h1FFFF;
            CFG_THRUST_SLEW:   r_tslew = val & 16'hFFFF;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (nav_queue.size() > 0 || in_valid || cmd_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // random beats: mostly route loads and aimed control steps, some noise
    task automatic random_beats(int count);
        int k, m, p, spread;
        for (int i = 0; i < count; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 10)
            begin
                m = ($urandom_range(0, 49) == 0) ? $urandom_range(62, 70)
                                                  : $urandom_range(1, 6);
                k = $urandom_range(0, 8000) - 4000;
                for (int j = 0; j < m; j++)
                    push_beat(CMD_STORE, j == 0, k + $urandom_range(0, 4000) - 2000,
                              k + $urandom_range(0, 4000) - 2000, 0);
            end
            else if (p < 20)
                push_beat($urandom_range(0, 1), $urandom_range(0, 1), $urandom,
                          $urandom, $urandom);
            else if (plan_e.size() == 0)
                push_beat(CMD_CONTROL, $urandom_range(0, 1), $urandom, $urandom, $urandom);
            else
            begin
                k = $urandom_range(0, plan_e.size() - 1);
                spread = ($urandom_range(0, 1) == 0) ? 60 : 3000;
                push_beat(CMD_CONTROL, $urandom_range(0, 1),
                          plan_e[k] + $urandom_range(0, 2 * spread) - spread,
                          plan_n[k] + $urandom_range(0, 2 * spread) - spread, $urandom);
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty list, arrivals, wrap, extremes, reload past end
        push_beat(CMD_CONTROL, 0, 0, 0, 0);
        push_beat(CMD_STORE, 1, 0, 0, 0);
        push_beat(CMD_STORE, 0, 1600, 0, 0);
        push_beat(CMD_STORE, 0, -1600, 800, 0);
        push_beat(CMD_CONTROL, 0, 0, 0, 0);
        push_beat(CMD_CONTROL, 0, 0, 0, 32767);
        push_beat(CMD_CONTROL, 1, 3200, 0, -32768);
        push_beat(CMD_CONTROL, 0, 32'sh80000000, 32'sh7FFFFFFF, 0);
        push_beat(CMD_CONTROL, 0, 32'sh7FFFFFFF, 32'sh80000000, -1);
        push_beat(CMD_CONTROL, 0, 1600, 0, 16384);
        push_beat(CMD_CONTROL, 0, -1600, 800, -16384);
        push_beat(CMD_CONTROL, 0, -65536, 0, 0);
        push_beat(CMD_CONTROL, 0, 0, 65535, 0);
        push_beat(CMD_CONTROL, 0, 0, 10, 0);
        push_beat(CMD_CONTROL, 0, 1610, 0, 0);
        push_beat(CMD_STORE, 1, 100, 100, 0);
        push_beat(CMD_CONTROL, 0, 100, 0, 0);
        push_beat(CMD_CONTROL, 0, 100, 200, 0);
        push_beat(CMD_CONTROL, 0, 0, 100, 0);
        drain();

        // full list, overflow store, then clear on a full list
        for (int j = 0; j < WPT_CAP + 2; j++)
            push_beat(CMD_STORE, j == 0, j * 40, -j * 40, 0);
        for (int j = 0; j < 6; j++)
            push_beat(CMD_CONTROL, 0, j * 40, -j * 40, j * 5000);
        push_beat(CMD_STORE, 1, 500, 500, 0);
        push_beat(CMD_CONTROL, 0, 500, 500, 0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            gap_cap = (ph % 3 == 2) ? 0 : 11;
            stall_cap = (ph % 4 == 3) ? 0 : 11;
            if (ph == 1)
            begin
                write_reg(CFG_ACCEPT_RADIUS, 0);
                write_reg(CFG_PROP_GAIN, 0);
                write_reg(CFG_DERIV_GAIN, 0);
                write_reg(CFG_CRUISE_THRUST, -25600);
                write_reg(CFG_STEER_LIMIT, 0);
                write_reg(CFG_STEER_SLEW, 0);
                write_reg(CFG_THRUST_SLEW, 0);
            end
            else if (ph == 2 || ph == 5)
            begin
                write_reg(CFG_ACCEPT_RADIUS, 65535);
                write_reg(CFG_PROP_GAIN, 65535);
                write_reg(CFG_DERIV_GAIN, 65535);
                write_reg(CFG_CRUISE_THRUST, ph == 2 ? 25600 : -25600);
                write_reg(CFG_STEER_LIMIT, 76800);
                write_reg(CFG_STEER_SLEW, 76800);
                write_reg(CFG_THRUST_SLEW, 51200);
            end
            else if (ph > 2)
            begin
                write_reg(CFG_ACCEPT_RADIUS, $urandom_range(0, 400));
                write_reg(CFG_PROP_GAIN, $urandom_range(0, 65535));
                write_reg(CFG_DERIV_GAIN, $urandom_range(0, 65535));
                write_reg(CFG_CRUISE_THRUST, int'($urandom_range(0, 51200)) - 25600);
                write_reg(CFG_STEER_LIMIT, $urandom_range(0, 76800));
                write_reg(CFG_STEER_SLEW, $urandom_range(0, 76800));
                write_reg(CFG_THRUST_SLEW, $urandom_range(0, 51200));
            end
            random_beats(155);
            drain();
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #8ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
hw/rtl/lwsc_pkg.sv
hw/rtl/lwsc_datapath.sv
hw/rtl/lwsc_ctrl.sv
hw/rtl/los_waypoint_steering_controller_core.sv
tb/testbench.sv
